/* sv/degree2_feature_expansion_macros.svh */
// Assertion macros for the degree-2 feature expansion block.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef DEGREE2_FEATURE_EXPANSION_MACROS_SVH
`define DEGREE2_FEATURE_EXPANSION_MACROS_SVH
`ifndef SYNTHESIS
`define DFE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dfe assertion failed");
`define DFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dfe assertion failed");
`else
`define DFE_ASSERT_IMP(lbl, ante, cons)
`define DFE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/dfe_pkg.sv */
// Shared constants, types and codes for the degree-2 feature expansion block.
// No dependencies.
package dfe_pkg;

  localparam int MAX_FEATURES  = 8;
  localparam int FEATURE_WIDTH = 32;
  localparam int FRAC_SHIFT    = 16;
  localparam int PRODUCT_W     = 64;
  localparam int COL_W         = 6;
  localparam int SAMPLE_W      = 16;
  localparam int FC_W          = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int POS_W         = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int D_W           = $clog2(MAX_FEATURES + 1);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = CFG_IDX_W'(1);

  typedef struct packed {
    logic signed [FEATURE_WIDTH-1:0] value;
    logic [POS_W-1:0]                pos;
    logic [SAMPLE_W-1:0]             sample;
    logic [D_W-1:0]                  d;
    logic                            last;
  } dfe_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dfe_qstat_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } dfe_bstat_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_PAIRS
  } dfe_seq_state_t;

endpackage

/* sv/dfe_fifo.sv */
// Short job queue between the front and back parts.
// Depends on dfe_pkg for the job type and queue depth.
module dfe_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dfe_pkg::dfe_job_t wr_data,
  input  logic              pop,
  output dfe_pkg::dfe_job_t rd_data,
  output dfe_pkg::dfe_qstat_t stat
);
  import dfe_pkg::*;

  dfe_job_t              mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]     count_r, count_nxt;

  assign stat.full  = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QUEUE_AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QUEUE_AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (QUEUE_AW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QUEUE_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* sv/dfe_front.sv */
// Front part: configuration registers, feature position and sample counting.
// Classifies each feature into a job for the queue. Depends on dfe_pkg.
module dfe_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [dfe_pkg::FEATURE_WIDTH-1:0] in_feature_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dfe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dfe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  dfe_pkg::dfe_qstat_t               q_stat,
  output logic                              push,
  output dfe_pkg::dfe_job_t                 job
);
  import dfe_pkg::*;

  logic [FC_W-1:0]     fc_r;
  logic [SAMPLE_W-1:0] samp_cnt_r;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [SAMPLE_W-1:0] smp_r, smp_nxt;
  logic [D_W-1:0]      d;
  logic [POS_W-1:0]    p;
  logic                last;
  logic [SAMPLE_W:0]   smp_inc;
  logic                cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = q_stat.full;
  assign push      = in_valid && !in_stall;

  always_comb begin
    if (fc_r == '0) begin
      d = D_W'(1);
    end else if (fc_r > FC_W'(MAX_FEATURES)) begin
      d = D_W'(MAX_FEATURES);
    end else begin
      d = D_W'(fc_r);
    end
    p       = (D_W'(pos_r) >= d) ? '0 : pos_r;
    last    = (D_W'(p) + D_W'(1)) >= d;
    smp_inc = {1'b0, smp_r} + (SAMPLE_W+1)'(1);
  end

  assign job.value  = in_feature_value;
  assign job.pos    = p;
  assign job.sample = smp_r;
  assign job.d      = d;
  assign job.last   = last;

  always_comb begin
    pos_nxt = pos_r;
    smp_nxt = smp_r;
    if (push) begin
      if (last) begin
        pos_nxt = '0;
        smp_nxt = (smp_inc >= {1'b0, samp_cnt_r}) ? '0 : smp_inc[SAMPLE_W-1:0];
      end else begin
        pos_nxt = p + POS_W'(1);
      end
    end
    if (cfg_wr && (cfg_index == CFG_FEATURE_COUNT)) begin
      pos_nxt = '0;
    end
    if (cfg_wr && (cfg_index == CFG_SAMPLE_COUNT)) begin
      pos_nxt = '0;
      smp_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r       <= FC_W'(8);
      samp_cnt_r <= SAMPLE_W'(65535);
      pos_r      <= '0;
      smp_r      <= '0;
    end else begin
      pos_r <= pos_nxt;
      smp_r <= smp_nxt;
      if (cfg_wr && (cfg_index == CFG_FEATURE_COUNT)) begin
        fc_r <= cfg_wdata[FC_W-1:0];
      end
      if (cfg_wr && (cfg_index == CFG_SAMPLE_COUNT)) begin
        samp_cnt_r <= cfg_wdata[SAMPLE_W-1:0];
      end
    end
  end

endmodule

/* sv/dfe_back.sv */
// Back part: feature store, pair sequencer, multiplier stage and output register.
// Takes jobs from the queue. Depends on dfe_pkg.
module dfe_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dfe_pkg::dfe_job_t                   job,
  input  dfe_pkg::dfe_qstat_t                 q_stat,
  output dfe_pkg::dfe_bstat_t                 bstat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dfe_pkg::PRODUCT_W-1:0] out_product_value,
  output logic [dfe_pkg::COL_W-1:0]           out_column_index,
  output logic [dfe_pkg::SAMPLE_W-1:0]        out_sample_index,
  output logic                                out_run_last
);
  import dfe_pkg::*;

  dfe_seq_state_t state_r, state_nxt;

  logic signed [FEATURE_WIDTH-1:0] store_r [MAX_FEATURES];

  logic [POS_W-1:0]    i_r, j_r;
  logic [D_W-1:0]      d_r;
  logic [COL_W-1:0]    col_r;
  logic [SAMPLE_W-1:0] smp_r;

  logic en, pop, issue_pair, pair_last, j_end;

  logic                            s1_valid_r;
  logic                            s1_first_r;
  logic signed [FEATURE_WIDTH-1:0] s1_a_r, s1_b_r;
  logic [COL_W-1:0]                s1_col_r;
  logic [SAMPLE_W-1:0]             s1_smp_r;
  logic                            s1_last_r;

  logic signed [2*FEATURE_WIDTH-1:0] prod;
  logic signed [PRODUCT_W-1:0]       result;
  logic                              out_valid_r;

  assign en = !out_valid_r || !out_stall;

  always_comb begin
    pop        = (state_r == SEQ_IDLE) && !q_stat.empty && en;
    issue_pair = (state_r == SEQ_PAIRS) && en;
    j_end      = (D_W'(j_r) == (d_r - D_W'(1)));
    pair_last  = j_end && (D_W'(i_r) == (d_r - D_W'(1)));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: begin
        if (pop && job.last) begin
          state_nxt = SEQ_PAIRS;
        end
      end
      SEQ_PAIRS: begin
        if (issue_pair && pair_last) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  assign bstat.pop  = pop;
  assign bstat.busy = (state_r == SEQ_PAIRS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (en) begin
        s1_valid_r  <= pop || issue_pair;
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      i_r   <= '0;
      j_r   <= '0;
      d_r   <= job.d;
      col_r <= COL_W'(job.d);
      smp_r <= job.sample;
    end else if (issue_pair) begin
      col_r <= col_r + COL_W'(1);
      if (j_end) begin
        i_r <= i_r + POS_W'(1);
        j_r <= i_r + POS_W'(1);
      end else begin
        j_r <= j_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      store_r[job.pos] <= job.value;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (issue_pair) begin
        s1_a_r     <= store_r[i_r];
        s1_b_r     <= store_r[j_r];
        s1_first_r <= 1'b0;
        s1_col_r   <= col_r;
        s1_smp_r   <= smp_r;
        s1_last_r  <= pair_last;
      end else begin
        s1_a_r     <= job.value;
        s1_b_r     <= job.value;
        s1_first_r <= 1'b1;
        s1_col_r   <= COL_W'(job.pos);
        s1_smp_r   <= job.sample;
        s1_last_r  <= !job.last;
      end
    end
  end

  always_comb begin
    prod = s1_a_r * s1_b_r;
    if (s1_first_r) begin
      result = PRODUCT_W'(s1_a_r) <<< FRAC_SHIFT;
    end else begin
      result = PRODUCT_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_product_value <= result;
      out_column_index  <= s1_col_r;
      out_sample_index  <= s1_smp_r;
      out_run_last      <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* sv/degree2_feature_expansion.sv */
// Top level of the degree-2 feature expansion block: front, job queue, back.
// Depends on dfe_pkg, dfe_front, dfe_fifo, dfe_back and the assertion macros.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_stall    feature_value
//   out_     output     out_valid/out_stall  product_value, column_index,
//                                            sample_index, run_last
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
// Each feature request yields one linear result in the back end's issue slot; the
// last one of its sample also yields d*(d+1)/2 pair products ahead of the next request.
// Each result is registered after the store read and again after the multiplier.
// Reset (rst_n low, synchronous) sets feature_count to 8 and sample_count to 65535.
// Out_stall freezes the back end; the two-entry job queue takes input until full.
`include "degree2_feature_expansion_macros.svh"
module degree2_feature_expansion (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [dfe_pkg::FEATURE_WIDTH-1:0] in_feature_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [dfe_pkg::PRODUCT_W-1:0]   out_product_value,
  output logic [dfe_pkg::COL_W-1:0]              out_column_index,
  output logic [dfe_pkg::SAMPLE_W-1:0]           out_sample_index,
  output logic                                   out_run_last,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dfe_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [dfe_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import dfe_pkg::*;

  dfe_job_t   front_job;
  dfe_job_t   queue_job;
  dfe_qstat_t q_stat;
  dfe_bstat_t bstat;
  logic       push;

  dfe_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_feature_value (in_feature_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .q_stat           (q_stat),
    .push             (push),
    .job              (front_job)
  );

  dfe_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (front_job),
    .pop     (bstat.pop),
    .rd_data (queue_job),
    .stat    (q_stat)
  );

  dfe_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job               (queue_job),
    .q_stat            (q_stat),
    .bstat             (bstat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_product_value (out_product_value),
    .out_column_index  (out_column_index),
    .out_sample_index  (out_sample_index),
    .out_run_last      (out_run_last)
  );

  `DFE_ASSERT_IMP(a_pop_not_empty, bstat.pop, !q_stat.empty)
  `DFE_ASSERT_IMP(a_push_not_full, push, !q_stat.full)
  `DFE_ASSERT_IMP(a_busy_no_pop, bstat.busy, !bstat.pop)
  `DFE_ASSERT_NEXT(a_full_after_push, q_stat.full && !bstat.pop, q_stat.full)

endmodule
